/* src/signed_int_to_ascii_digits_core_assert.svh */
// Assertion helpers shared by the modules of the converter.
// Each macro samples on the rising edge of clk and is held off while arst_n is low.
`ifndef SIGNED_INT_TO_ASCII_DIGITS_CORE_ASSERT_SVH
`define SIGNED_INT_TO_ASCII_DIGITS_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIA_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sia: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SIA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sia: next-cycle check failed");

`endif

/* src/sia_pkg.sv */
package sia_pkg;

	// Input request: a signed number and the radix choice.
	typedef struct packed {
		logic signed [15:0] value;
		logic               radix_is_hex;
	} item_t;

	// One output character.
	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} text_t;

	// Classified work handed from the front part to the back part.
	typedef struct packed {
		logic        neg;
		logic        hex;
		logic [15:0] mag;
	} work_t;

	localparam logic [7:0] CHAR_ZERO        = 8'h30;
	localparam logic [7:0] CHAR_MINUS       = 8'h2D;
	localparam logic [7:0] HEX_ALPHA_OFFSET = 8'd7;
	localparam logic [3:0] DEC_RADIX        = 4'd10;

	// Digit positions are counted from the least significant digit.
	localparam logic [2:0] DEC_TOP_POS = 3'd4;
	localparam logic [2:0] HEX_TOP_POS = 3'd3;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		if (d < DEC_RADIX) begin
			return CHAR_ZERO + 8'(d);
		end else begin
			return CHAR_ZERO + HEX_ALPHA_OFFSET + 8'(d);
		end
	endfunction

	function automatic logic [16:0] pow10(input logic [2:0] pos);
		logic [16:0] p;
		case (pos)
			3'd0:    p = 17'd1;
			3'd1:    p = 17'd10;
			3'd2:    p = 17'd100;
			3'd3:    p = 17'd1000;
			3'd4:    p = 17'd10000;
			default: p = 17'd0;
		endcase
		return p;
	endfunction

	// k times ten to the power pos; k is a constant at every call site.
	function automatic logic [16:0] dec_mult(input logic [2:0] pos, input logic [3:0] k);
		logic [20:0] prod;
		prod = 21'(pow10(pos)) * 21'(k);
		return prod[16:0];
	endfunction

endpackage

/* src/sia_stream_if.sv */
interface sia_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

/* src/sia_front.sv */
module sia_front
	import sia_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	sia_stream_if.sink   item,
	output logic         push_valid,
	output work_t        push_work,
	input  logic         push_ready
);

	logic  v_s1;
	work_t work_s1;

	// The stage frees up whenever its content moves on into the queue.
	assign item.ready = !v_s1 || push_ready;
	assign push_valid = v_s1;
	assign push_work  = work_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	// Sign and magnitude; the most negative value yields 0x8000 unsigned.
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			work_s1.neg <= item.payload.value[15];
			work_s1.hex <= item.payload.radix_is_hex;
			work_s1.mag <= item.payload.value[15] ? 16'(~item.payload.value + 16'sd1)
			                                      : 16'(item.payload.value);
		end
	end

endmodule

/* src/sia_queue.sv */
module sia_queue
	import sia_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  work_t push_work,
	output logic  pop_valid,
	input  logic  pop_ready,
	output work_t pop_work
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	work_t         mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_work   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wrap_inc(wr_q);
			end
			if (pop) begin
				rd_q <= wrap_inc(rd_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_work;
		end
	end

`include "signed_int_to_ascii_digits_core_assert.svh"

	`SIA_ASSERT_IMPLIES(a_count_bound, 1'b1, count_q <= CW'(DEPTH))

endmodule

/* src/sia_back.sv */
module sia_back
	import sia_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         pop_valid,
	output logic         pop_ready,
	input  work_t        pop_work,
	sia_stream_if.source text
);

	logic        busy_q;
	logic        neg_q;
	logic        hex_q;
	logic        started_q;
	logic [2:0]  pos_q;
	logic [15:0] rem_q;
	logic        out_v_q;
	logic [7:0]  out_char_q;
	logic        out_last_q;

	logic        can;
	logic [3:0]  d_dec;
	logic [16:0] sub_dec;
	logic [3:0]  d_hex;
	logic [3:0]  digit;
	logic        emit_now;
	logic        emit_sign;
	logic        emit_digit;
	logic        skip;
	logic        finish;
	logic        take;

	assign text.valid             = out_v_q;
	assign text.payload.char_code = out_char_q;
	assign text.payload.last_char = out_last_q;

	// The output register can take a character when empty or being drained.
	assign can = !out_v_q || text.ready;

	// Decimal digit at the current position: the largest multiple that fits.
	always_comb begin
		d_dec   = '0;
		sub_dec = '0;
		for (int k = 1; k < 10; k++) begin
			if ({1'b0, rem_q} >= dec_mult(pos_q, 4'(k))) begin
				d_dec   = 4'(k);
				sub_dec = dec_mult(pos_q, 4'(k));
			end
		end
	end

	assign d_hex = rem_q[{pos_q[1:0], 2'b00} +: 4];
	assign digit = hex_q ? d_hex : d_dec;

	// Leading zeros are dropped, but the units digit always goes out.
	assign emit_now   = started_q || (digit != '0) || (pos_q == '0);
	assign emit_sign  = busy_q && neg_q && can;
	assign emit_digit = busy_q && !neg_q && emit_now && can;
	assign skip       = busy_q && !neg_q && !emit_now;
	assign finish     = emit_digit && (pos_q == '0);
	assign pop_ready  = !busy_q || finish;
	assign take       = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			neg_q      <= 1'b0;
			started_q  <= 1'b0;
			pos_q      <= '0;
			out_v_q    <= 1'b0;
		end else begin
			if (take) begin
				busy_q    <= 1'b1;
				neg_q     <= pop_work.neg;
				started_q <= 1'b0;
				pos_q     <= pop_work.hex ? HEX_TOP_POS : DEC_TOP_POS;
			end else if (finish) begin
				busy_q <= 1'b0;
			end else if (emit_sign) begin
				neg_q <= 1'b0;
			end else if (emit_digit || skip) begin
				pos_q     <= pos_q - 3'd1;
				started_q <= started_q || emit_digit;
			end

			if (emit_sign || emit_digit) begin
				out_v_q <= 1'b1;
			end else if (text.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			hex_q <= pop_work.hex;
			rem_q <= pop_work.mag;
		end else if (emit_digit && !hex_q) begin
			rem_q <= rem_q - sub_dec[15:0];
		end

		if (emit_sign) begin
			out_char_q <= CHAR_MINUS;
			out_last_q <= 1'b0;
		end else if (emit_digit) begin
			out_char_q <= digit_char(digit);
			out_last_q <= finish;
		end
	end

`include "signed_int_to_ascii_digits_core_assert.svh"

	`SIA_ASSERT_NEXT(a_finish_idle, finish && !take, !busy_q)
	`SIA_ASSERT_IMPLIES(a_sign_first, emit_sign, !started_q)
	`SIA_ASSERT_IMPLIES(a_pos_range, busy_q, (pos_q <= DEC_TOP_POS) && (!hex_q || (pos_q <= HEX_TOP_POS)))

endmodule

/* src/signed_int_to_ascii_digits_core.sv */
// Converts a 16-bit two's complement number into ASCII text, one character per
// output request, most significant character first. radix_is_hex selects decimal
// ('0'-'9') or hexadecimal ('0'-'9', 'A'-'F') digits; negative numbers get a leading
// '-', leading zeros are dropped, zero prints as "0", and the most negative value
// prints as "-32768" or "-8000". last_char is set on the final character of each
// number. A front stage registers each request and splits it into sign and
// magnitude, a small queue (QUEUE_DEPTH entries) holds classified numbers, and a
// back part walks the digit positions from the most significant one down, one
// position per cycle while the output is not stalled: decimal numbers have five
// positions and hex numbers four, plus a step for the sign when negative. Dropped
// leading zeros are still walked as positions. The next number is taken from the
// queue in the same cycle as the last character of the current one, and the front
// keeps accepting requests while the queue has room. Nothing is carried from one
// number to the next.
module signed_int_to_ascii_digits_core
	import sia_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	sia_stream_if.sink   item,
	sia_stream_if.source text
);

	// Front stage to queue.
	logic  push_valid;
	logic  push_ready;
	work_t push_work;

	// Queue to back part.
	logic  pop_valid;
	logic  pop_ready;
	work_t pop_work;

	sia_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push_valid (push_valid),
		.push_work  (push_work),
		.push_ready (push_ready)
	);

	// The queue lets the front keep taking numbers while the back is still
	// printing an earlier one.
	sia_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_work  (push_work),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_work   (pop_work)
	);

	// The back part owns the output register; a stalled character holds the back
	// part, and once the queue is full the front stalls as well.
	sia_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_work  (pop_work),
		.text      (text)
	);

endmodule
